### src/kwl_pkg.sv
// Shared types, constants and character classifiers for the keyword token lexer.
// Used by kwl_ctrl, kwl_dp and keyword_token_lexer; no dependencies.
`timescale 1ns / 1ps

package kwl_pkg;

    localparam int MAX_ID_LEN = 32;
    localparam int ADDR_W     = $clog2(MAX_ID_LEN);
    localparam int LEN_W      = $clog2(MAX_ID_LEN + 1);
    localparam int PREFIX_LEN = 4;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [4:0] {
        TK_END     = 5'd0,
        TK_INTEGER = 5'd1,
        TK_PLUS    = 5'd2,
        TK_MINUS   = 5'd3,
        TK_LESS    = 5'd4,
        TK_GREATER = 5'd5,
        TK_SEMI    = 5'd6,
        TK_LPAREN  = 5'd7,
        TK_RPAREN  = 5'd8,
        TK_LBRACE  = 5'd9,
        TK_RBRACE  = 5'd10,
        TK_ASSIGN  = 5'd11,
        TK_COMMA   = 5'd12,
        TK_IF      = 5'd13,
        TK_ELSE    = 5'd14,
        TK_DEF     = 5'd15,
        TK_FUNC    = 5'd16,
        TK_ID      = 5'd17,
        TK_UNKNOWN = 5'd18
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ID,
        ST_OWN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_PEND,
        SEL_OWN_IN,
        SEL_OWN_HELD,
        SEL_ID
    } out_sel_t;

    typedef struct packed {
        logic     step;        // lex the incoming byte: extend or restart
        logic     hold;        // stash the incoming byte for later
        logic     fresh_held;  // restart lexing from the stashed byte
        logic     id_start;    // begin an identifier run at entry 0
        logic     id_advance;  // move to the next identifier character
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last_run;
    } kwl_cmd_t;

    typedef struct packed {
        logic mode_num;
        logic mode_word;
        logic in_digit;
        logic in_alnum;
        logic own_now;   // incoming byte makes a token by itself
        logic own_held;  // stashed byte makes a token by itself
        logic word_kw;   // buffered word is a keyword
        logic id_last;   // current identifier character is the final one
    } kwl_status_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
    } own_token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Token made by a byte on its own; digits, letters and whitespace make none.
    function automatic own_token_t own_token(input logic [7:0] c);
        own_token_t t;
        t.valid = !(is_digit(c) || is_alpha(c) || is_space(c));
        case (c)
            8'h00:   t.kind = TK_END;
            8'h2B:   t.kind = TK_PLUS;
            8'h2D:   t.kind = TK_MINUS;
            8'h3C:   t.kind = TK_LESS;
            8'h3E:   t.kind = TK_GREATER;
            8'h3B:   t.kind = TK_SEMI;
            8'h28:   t.kind = TK_LPAREN;
            8'h29:   t.kind = TK_RPAREN;
            8'h7B:   t.kind = TK_LBRACE;
            8'h7D:   t.kind = TK_RBRACE;
            8'h3D:   t.kind = TK_ASSIGN;
            8'h2C:   t.kind = TK_COMMA;
            default: t.kind = TK_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

### src/kwl_ctrl.sv
// Sequencing controller for the keyword token lexer: input accept, identifier
// flush and deferred token states, plus the output valid flag. Uses kwl_pkg.
`timescale 1ns / 1ps

module kwl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  kwl_pkg::kwl_status_t status,
    output kwl_pkg::kwl_cmd_t    cmd
);

    kwl_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 can_load;
    logic                 pend_num, pend_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kwl_pkg::ST_RUN;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        can_load   = !m_tvalid_reg || m_tready;
        pend_num   = status.mode_num && !status.in_digit;
        pend_word  = status.mode_word && !status.in_alnum;
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.out_sel = kwl_pkg::SEL_PEND;

        unique case (state_reg)
            kwl_pkg::ST_RUN: begin
                s_tready = can_load;
                if (s_tvalid && can_load) begin
                    if (pend_word && !status.word_kw) begin
                        // hold the byte until the identifier run drains
                        cmd.hold     = 1'b1;
                        cmd.id_start = 1'b1;
                        state_next   = kwl_pkg::ST_ID;
                    end else begin
                        cmd.step = 1'b1;
                        if (pend_num || pend_word) begin
                            cmd.out_load     = 1'b1;
                            cmd.out_sel      = kwl_pkg::SEL_PEND;
                            cmd.out_last_run = !status.own_now;
                            if (status.own_now) begin
                                cmd.hold   = 1'b1;
                                state_next = kwl_pkg::ST_OWN;
                            end
                        end else if (status.own_now) begin
                            cmd.out_load     = 1'b1;
                            cmd.out_sel      = kwl_pkg::SEL_OWN_IN;
                            cmd.out_last_run = 1'b1;
                        end
                    end
                end
            end
            kwl_pkg::ST_ID: begin
                if (can_load) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = kwl_pkg::SEL_ID;
                    cmd.out_last_run = status.id_last && !status.own_held;
                    cmd.id_advance   = 1'b1;
                    if (status.id_last) begin
                        cmd.fresh_held = 1'b1;
                        state_next     = status.own_held ? kwl_pkg::ST_OWN : kwl_pkg::ST_RUN;
                    end
                end
            end
            kwl_pkg::ST_OWN: begin
                if (can_load) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = kwl_pkg::SEL_OWN_HELD;
                    cmd.out_last_run = 1'b1;
                    state_next       = kwl_pkg::ST_RUN;
                end
            end
            default: state_next = kwl_pkg::ST_RUN;
        endcase

        m_tvalid_next = cmd.out_load || (m_tvalid_reg && !m_tready);
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### src/kwl_dp.sv
// Datapath for the keyword token lexer: number accumulator, word buffer memory,
// keyword prefix, stashed byte and the output payload register. Uses kwl_pkg.
`timescale 1ns / 1ps

module kwl_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  kwl_pkg::kwl_cmd_t    cmd,
    output kwl_pkg::kwl_status_t status,
    output logic [47:0]          m_tdata,
    output logic                 m_tlast
);

    kwl_pkg::scan_mode_t        mode_reg, mode_next;
    logic [31:0]                acc_reg, acc_next;
    logic [kwl_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       trunc_reg, trunc_next;
    logic [kwl_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [7:0]                 hold_reg;
    logic [7:0]                 rd_reg;
    logic [7:0]                 prefix_reg [kwl_pkg::PREFIX_LEN];
    logic [7:0]                 word_mem [kwl_pkg::MAX_ID_LEN];

    logic                       wr_en;
    logic [kwl_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       pre_we;
    logic [1:0]                 pre_idx;

    logic                       extend, do_fresh;
    logic [7:0]                 fc;
    kwl_pkg::own_token_t        own_in, own_held;
    kwl_pkg::token_kind_t       kw_kind;
    logic                       kw_hit;

    // Output payload
    kwl_pkg::token_kind_t       kind_reg, kind_next;
    logic [31:0]                value_reg, value_next;
    logic [7:0]                 text_reg, text_next;
    logic                       otrunc_reg, otrunc_next;
    logic                       lot_reg, lot_next;
    logic                       last_reg;

    function automatic logic pfx_is(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c0, input logic [7:0] c1);
        return (a == c0) && (b == c1);
    endfunction

    always_comb begin
        own_in   = kwl_pkg::own_token(s_tdata);
        own_held = kwl_pkg::own_token(hold_reg);

        // Keyword match over the buffered prefix
        kw_hit  = 1'b0;
        kw_kind = kwl_pkg::TK_ID;
        if (!trunc_reg) begin
            if (len_reg == kwl_pkg::LEN_W'(2)
                && pfx_is(prefix_reg[0], prefix_reg[1], 8'h69, 8'h66)) begin
                kw_hit  = 1'b1;
                kw_kind = kwl_pkg::TK_IF;
            end else if (len_reg == kwl_pkg::LEN_W'(4)
                && pfx_is(prefix_reg[0], prefix_reg[1], 8'h65, 8'h6C)
                && pfx_is(prefix_reg[2], prefix_reg[3], 8'h73, 8'h65)) begin
                kw_hit  = 1'b1;
                kw_kind = kwl_pkg::TK_ELSE;
            end else if (len_reg == kwl_pkg::LEN_W'(3)
                && pfx_is(prefix_reg[0], prefix_reg[1], 8'h64, 8'h65)
                && prefix_reg[2] == 8'h66) begin
                kw_hit  = 1'b1;
                kw_kind = kwl_pkg::TK_DEF;
            end else if (len_reg == kwl_pkg::LEN_W'(4)
                && pfx_is(prefix_reg[0], prefix_reg[1], 8'h66, 8'h75)
                && pfx_is(prefix_reg[2], prefix_reg[3], 8'h6E, 8'h63)) begin
                kw_hit  = 1'b1;
                kw_kind = kwl_pkg::TK_FUNC;
            end
        end

        status.mode_num  = (mode_reg == kwl_pkg::MODE_NUM);
        status.mode_word = (mode_reg == kwl_pkg::MODE_WORD);
        status.in_digit  = kwl_pkg::is_digit(s_tdata);
        status.in_alnum  = kwl_pkg::is_digit(s_tdata) || kwl_pkg::is_alpha(s_tdata);
        status.own_now   = own_in.valid;
        status.own_held  = own_held.valid;
        status.word_kw   = kw_hit;
        status.id_last   = (kwl_pkg::LEN_W'(idx_reg + kwl_pkg::LEN_W'(1)) == len_reg);
    end

    // Lexer state update
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        trunc_next = trunc_reg;
        wr_en      = 1'b0;
        wr_addr    = len_reg[kwl_pkg::ADDR_W-1:0];
        wr_data    = s_tdata;
        pre_we     = 1'b0;
        pre_idx    = len_reg[1:0];

        extend = cmd.step && ((status.mode_num && status.in_digit)
                              || (status.mode_word && status.in_alnum));
        do_fresh = cmd.fresh_held || (cmd.step && !extend);
        fc       = cmd.fresh_held ? hold_reg : s_tdata;

        if (extend) begin
            if (status.mode_num) begin
                acc_next = acc_reg * 32'd10 + {24'd0, s_tdata - kwl_pkg::CH_ZERO};
            end else if (len_reg < kwl_pkg::LEN_W'(kwl_pkg::MAX_ID_LEN)) begin
                wr_en    = 1'b1;
                pre_we   = (len_reg < kwl_pkg::LEN_W'(kwl_pkg::PREFIX_LEN));
                len_next = len_reg + kwl_pkg::LEN_W'(1);
            end else begin
                // drop the character, mark the word cut
                trunc_next = 1'b1;
            end
        end else if (do_fresh) begin
            acc_next   = '0;
            len_next   = '0;
            trunc_next = 1'b0;
            mode_next  = kwl_pkg::MODE_IDLE;
            if (kwl_pkg::is_digit(fc)) begin
                acc_next  = {24'd0, fc - kwl_pkg::CH_ZERO};
                mode_next = kwl_pkg::MODE_NUM;
            end else if (kwl_pkg::is_alpha(fc)) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = fc;
                pre_we    = 1'b1;
                pre_idx   = 2'd0;
                len_next  = kwl_pkg::LEN_W'(1);
                mode_next = kwl_pkg::MODE_WORD;
            end
        end

        if (cmd.id_start) begin
            idx_next = '0;
        end else if (cmd.id_advance) begin
            idx_next = idx_reg + kwl_pkg::LEN_W'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    // Result selection
    always_comb begin
        kind_next   = kwl_pkg::TK_END;
        value_next  = '0;
        text_next   = '0;
        otrunc_next = 1'b0;
        lot_next    = 1'b1;
        case (cmd.out_sel)
            kwl_pkg::SEL_PEND: begin
                if (status.mode_num) begin
                    kind_next  = kwl_pkg::TK_INTEGER;
                    value_next = acc_reg;
                end else begin
                    kind_next = kw_kind;
                end
            end
            kwl_pkg::SEL_OWN_IN: begin
                kind_next = own_in.kind;
                if (own_in.kind == kwl_pkg::TK_UNKNOWN) begin
                    text_next = s_tdata;
                end
            end
            kwl_pkg::SEL_OWN_HELD: begin
                kind_next = own_held.kind;
                if (own_held.kind == kwl_pkg::TK_UNKNOWN) begin
                    text_next = hold_reg;
                end
            end
            default: begin
                kind_next   = kwl_pkg::TK_ID;
                text_next   = rd_reg;
                otrunc_next = trunc_reg;
                lot_next    = status.id_last;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= kwl_pkg::MODE_IDLE;
            acc_reg   <= '0;
            len_reg   <= '0;
            trunc_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            trunc_reg <= trunc_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem[wr_addr] <= wr_data;
        end
        rd_reg <= word_mem[idx_next[kwl_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pre_we) begin
            prefix_reg[pre_idx] <= wr_data;
        end
        if (cmd.hold) begin
            hold_reg <= s_tdata;
        end
        if (cmd.out_load) begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            text_reg   <= text_next;
            otrunc_reg <= otrunc_next;
            lot_reg    <= lot_next;
            last_reg   <= cmd.out_last_run;
        end
    end

    assign m_tdata = {1'b0, lot_reg, otrunc_reg, text_reg, value_reg, kind_reg};
    assign m_tlast = last_reg;

endmodule

### src/keyword_token_lexer.sv
// Top level of the keyword token lexer: joins the controller and the datapath.
// Depends on kwl_pkg, kwl_ctrl and kwl_dp.
//
//  channel | dir | tdata (low bit up)                                  | tuser | tlast
//  s_      | in  | input_char[7:0]                                     | -     | -
//  m_      | out | token_kind[4:0] number_value[36:5] text_char[44:37] | -     | last_of_run
//          |     | word_truncated[45] last_of_token[46] zero[47]       |       |
//
// One byte per cycle while the lexer extends a token or emits a single result, as long as m_ is not stalled.
// A byte that ends a number or keyword and makes a token itself is stashed and emits its token from ST_OWN.
// A byte that ends an identifier of n characters is stashed while ST_ID drains the n characters from
// the word buffer memory (one read per cycle while m_ is not stalled), then ST_OWN emits one more
// result when the byte makes its own token.
// Results pass through one output register; a stalled m_ side stalls s_ input.
// Reset is synchronous, active low, and returns the lexer to idle between tokens.
`timescale 1ns / 1ps

module keyword_token_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // input_char[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // token_kind, number_value, text_char,
                                   // word_truncated, last_of_token, pad
    output logic        m_tlast
);

    kwl_pkg::kwl_cmd_t    cmd;
    kwl_pkg::kwl_status_t status;

    kwl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kwl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // No input is taken while an identifier run drains
    a_no_accept_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && cmd.out_load && cmd.out_sel == kwl_pkg::SEL_ID))
        else $error("input accepted during identifier flush");

    // An identifier character that is not the last of its word never ends a run
    a_id_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:0] == kwl_pkg::TK_ID && !m_tdata[46] |-> !m_tlast)
        else $error("run ended inside an identifier");

    // Only integer results carry a value
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4:0] != kwl_pkg::TK_INTEGER |-> m_tdata[36:5] == 32'd0)
        else $error("value on a non-integer result");

endmodule
